FILE: rtl/core/llf_pkg.sv
// llf_pkg: shared widths, command and register codes, state and tag types
// for the fully connected layer block; no dependencies
package llf_pkg;

  localparam int VALUE_W   = 16;  // q4.12 weight, bias and activation
  localparam int PROD_W    = 32;  // one q8.24 product
  localparam int ACC_W     = 48;  // q.24 dot product
  localparam int FRAC_BITS = 12;  // aligns a q4.12 bias to q.24
  localparam int CH_W      = 6;
  localparam int POS_W     = 6;
  localparam int FEAT_W    = 7;
  localparam int TOK_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_ACT    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_FEATURES  = 2'd0,
    REG_OUT_FEATURES = 2'd1,
    REG_BIAS_ENABLE  = 2'd2,
    REG_TOKEN_COUNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // one multiply-accumulate step as it travels down the pipeline
  typedef struct packed {
    logic            vld;
    logic            first;
    logic            last;
    logic            last_chan;
    logic            bias_en;
    logic [CH_W-1:0] ch;
  } tag_t;

endpackage

FILE: rtl/core/llf_in_if.sv
// llf_in_if: input item channel (load weight, load bias, activation)
// depends on llf_pkg
interface llf_in_if import llf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [CH_W-1:0]           channel;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, channel, position, value, input ready);
  modport sink   (input valid, command, channel, position, value, output ready);
endinterface

FILE: rtl/core/llf_out_if.sv
// llf_out_if: result item channel, one dot product per output channel
// depends on llf_pkg
interface llf_out_if import llf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] out_value;
  logic [CH_W-1:0]         out_channel;
  logic                    last_channel;
  logic                    last_token;

  modport source (output valid, out_value, out_channel, last_channel, last_token,
                  input ready);
  modport sink   (input valid, out_value, out_channel, last_channel, last_token,
                  output ready);
endinterface

FILE: rtl/core/llf_store.sv
// llf_store: weight matrix, bias vector and input row memories
// registered reads advance with the pipeline; depends on llf_pkg
module llf_store import llf_pkg::*; #(
  parameter int MAX_IN_FEATURES  = 64,
  parameter int MAX_OUT_FEATURES = 64,
  parameter int IW               = 6,
  parameter int OW               = 6,
  parameter int WAW              = 12
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic                      w_we,
  input  logic [WAW-1:0]            w_waddr,
  input  logic                      b_we,
  input  logic [OW-1:0]             b_waddr,
  input  logic                      x_we,
  input  logic [IW-1:0]             x_waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [WAW-1:0]            w_raddr,
  input  logic [OW-1:0]             b_raddr,
  input  logic [IW-1:0]             x_raddr,
  output logic signed [VALUE_W-1:0] w_rd,
  output logic signed [VALUE_W-1:0] b_rd,
  output logic signed [VALUE_W-1:0] x_rd
);

  logic signed [VALUE_W-1:0] w_mem [MAX_OUT_FEATURES*MAX_IN_FEATURES];
  logic signed [VALUE_W-1:0] b_mem [MAX_OUT_FEATURES];
  logic signed [VALUE_W-1:0] x_mem [MAX_IN_FEATURES];

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= wdata;
    end
    if (adv) begin
      w_rd <= w_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= wdata;
    end
    if (adv) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_waddr] <= wdata;
    end
    if (adv) begin
      x_rd <= x_mem[x_raddr];
    end
  end

endmodule

FILE: rtl/core/llf_mac.sv
// llf_mac: shared multiply-accumulate unit with the result output register
// depends on llf_pkg and llf_out_if
module llf_mac import llf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  tag_t                      issue,
  input  logic signed [VALUE_W-1:0] w_rd,
  input  logic signed [VALUE_W-1:0] b_rd,
  input  logic signed [VALUE_W-1:0] x_rd,
  input  logic                      last_tok,
  output logic                      adv,
  output logic                      busy,
  llf_out_if.source                 rsp
);

  tag_t                    s1;
  tag_t                    s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum;
  logic                     done;

  // hold everything while a finished sum cannot enter the output register
  assign adv  = !(s2.vld && s2.last && rsp.valid && !rsp.ready);
  assign busy = s1.vld || s2.vld;
  assign done = adv && s2.vld && s2.last;
  assign sum  = (s2.first ? base : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else if (adv) begin
      s1 <= issue;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= x_rd * w_rd;
      base <= s1.bias_en ? (ACC_W'(b_rd) <<< FRAC_BITS) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2.vld) begin
      acc <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.out_value    <= sum;
      rsp.out_channel  <= s2.ch;
      rsp.last_channel <= s2.last_chan;
      rsp.last_token   <= last_tok;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s2))
    else $error("pipeline moved during a stall");

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    done |=> rsp.valid)
    else $error("finished sum did not reach the output");

endmodule

FILE: rtl/core/llf_seq.sv
// llf_seq: sequencer that walks channels and features over the shared unit,
// plus the token counter; depends on llf_pkg
module llf_seq import llf_pkg::*; #(
  parameter int MAX_IN_FEATURES = 64,
  parameter int IW              = 6,
  parameter int OW              = 6,
  parameter int NIW             = 7,
  parameter int NOW             = 7,
  parameter int WAW             = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NIW-1:0]   n_in,
  input  logic [NOW-1:0]   n_out,
  input  logic             bias_en,
  input  logic [TOK_W-1:0] token_count,
  input  logic             adv,
  input  logic             busy,
  output logic             idle,
  output tag_t             issue,
  output logic [IW-1:0]    x_raddr,
  output logic [WAW-1:0]   w_raddr,
  output logic [OW-1:0]    b_raddr,
  output logic             last_tok
);

  state_t           state;
  state_t           state_next;
  logic [IW-1:0]    i_cnt;
  logic [OW-1:0]    o_cnt;
  logic [WAW-1:0]   w_base;
  logic [TOK_W-1:0] tok_cnt;
  logic [TOK_W-1:0] tokens;
  logic             tok_last;
  logic             i_last;
  logic             o_last;

  assign i_last = (NIW'(i_cnt) == n_in - NIW'(1));
  assign o_last = (NOW'(o_cnt) == n_out - NOW'(1));
  assign idle   = (state == ST_IDLE);

  assign issue.vld       = (state == ST_RUN);
  assign issue.first     = (i_cnt == '0);
  assign issue.last      = i_last;
  assign issue.last_chan = o_last;
  assign issue.bias_en   = bias_en;
  assign issue.ch        = CH_W'(o_cnt);

  assign x_raddr = i_cnt;
  assign w_raddr = w_base + WAW'(i_cnt);
  assign b_raddr = o_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (adv && i_last && o_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt  <= '0;
      o_cnt  <= '0;
      w_base <= '0;
    end else if (start) begin
      i_cnt  <= '0;
      o_cnt  <= '0;
      w_base <= '0;
    end else if (state == ST_RUN && adv) begin
      if (i_last) begin
        i_cnt  <= '0;
        o_cnt  <= o_cnt + OW'(1);
        w_base <= w_base + WAW'(MAX_IN_FEATURES);
      end else begin
        i_cnt <= i_cnt + IW'(1);
      end
    end
  end

  assign tokens   = (token_count == '0) ? TOK_W'(1) : token_count;
  assign tok_last = ({1'b0, tok_cnt} + (TOK_W+1)'(1)) >= {1'b0, tokens};

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_cnt  <= '0;
      last_tok <= 1'b0;
    end else if (start) begin
      tok_cnt  <= tok_last ? '0 : tok_cnt + TOK_W'(1);
      last_tok <= tok_last;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("token started while busy");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !busy)
    else $error("idle with work still in the pipeline");

endmodule

FILE: rtl/core/linear_layer_forward.sv
// linear_layer_forward: fully connected layer, q4.12 in, q.24 sums out
// a load or a non-final activation item is taken whenever the block is idle;
// the final activation of a row starts n_out*n_in multiply-accumulates on one
// shared unit (one per cycle unless the output stalls), giving one result per
// output channel, and no new item is taken until the pass is done
// reset: control and registers to defaults, memories hold no reset value
module linear_layer_forward import llf_pkg::*; #(
  parameter int MAX_IN_FEATURES  = 64,
  parameter int MAX_OUT_FEATURES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  llf_in_if.sink               req,
  llf_out_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW  = (MAX_IN_FEATURES > 1) ? $clog2(MAX_IN_FEATURES) : 1;
  localparam int OW  = (MAX_OUT_FEATURES > 1) ? $clog2(MAX_OUT_FEATURES) : 1;
  localparam int NIW = $clog2(MAX_IN_FEATURES + 1);
  localparam int NOW = $clog2(MAX_OUT_FEATURES + 1);
  localparam int WD  = MAX_OUT_FEATURES * MAX_IN_FEATURES;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

  // configuration registers
  logic [FEAT_W-1:0] in_features;
  logic [FEAT_W-1:0] out_features;
  logic              bias_enable;
  logic [TOK_W-1:0]  token_count;

  // clamped feature counts
  logic [NIW-1:0] n_in;
  logic [NOW-1:0] n_out;

  // input decode
  logic           in_acc;
  logic           ch_ok;
  logic           pos_ok;
  logic           w_we;
  logic           b_we;
  logic           x_we;
  logic           start;
  logic [WAW-1:0] w_waddr;

  // pipeline wiring
  tag_t                      issue;
  logic                      adv;
  logic                      busy;
  logic                      idle;
  logic                      last_tok;
  logic [IW-1:0]             x_raddr;
  logic [WAW-1:0]            w_raddr;
  logic [OW-1:0]             b_raddr;
  logic signed [VALUE_W-1:0] w_rd;
  logic signed [VALUE_W-1:0] b_rd;
  logic signed [VALUE_W-1:0] x_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_features  <= FEAT_W'(64);
      out_features <= FEAT_W'(64);
      bias_enable  <= 1'b1;
      token_count  <= TOK_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IN_FEATURES:  in_features  <= cfg_data[FEAT_W-1:0];
        REG_OUT_FEATURES: out_features <= cfg_data[FEAT_W-1:0];
        REG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        REG_TOKEN_COUNT:  token_count  <= cfg_data[TOK_W-1:0];
      endcase
    end
  end

  // zero acts as one, anything above the store size as the store size
  always_comb begin
    if (in_features == '0) begin
      n_in = NIW'(1);
    end else if (32'(in_features) > MAX_IN_FEATURES) begin
      n_in = NIW'(MAX_IN_FEATURES);
    end else begin
      n_in = NIW'(in_features);
    end
    if (out_features == '0) begin
      n_out = NOW'(1);
    end else if (32'(out_features) > MAX_OUT_FEATURES) begin
      n_out = NOW'(MAX_OUT_FEATURES);
    end else begin
      n_out = NOW'(out_features);
    end
  end

  // new items only while the sequencer sits idle
  assign req.ready = idle;
  assign in_acc    = req.valid && req.ready;

  // loads outside the stores and activations past the row are dropped
  assign ch_ok   = 32'(req.channel) < MAX_OUT_FEATURES;
  assign pos_ok  = 32'(req.position) < MAX_IN_FEATURES;
  assign w_we    = in_acc && (req.command == CMD_WEIGHT) && ch_ok && pos_ok;
  assign b_we    = in_acc && (req.command == CMD_BIAS) && ch_ok;
  assign x_we    = in_acc && (req.command == CMD_ACT) && (32'(req.position) < 32'(n_in));
  assign w_waddr = WAW'(32'(req.channel) * MAX_IN_FEATURES + 32'(req.position));

  // the last feature of the row kicks off the matrix-vector pass
  assign start = x_we && (32'(req.position) == 32'(n_in) - 32'd1);

  llf_store #(
    .MAX_IN_FEATURES  (MAX_IN_FEATURES),
    .MAX_OUT_FEATURES (MAX_OUT_FEATURES),
    .IW               (IW),
    .OW               (OW),
    .WAW              (WAW)
  ) u_store (
    .clk     (clk),
    .adv     (adv),
    .w_we    (w_we),
    .w_waddr (w_waddr),
    .b_we    (b_we),
    .b_waddr (OW'(req.channel)),
    .x_we    (x_we),
    .x_waddr (IW'(req.position)),
    .wdata   (req.value),
    .w_raddr (w_raddr),
    .b_raddr (b_raddr),
    .x_raddr (x_raddr),
    .w_rd    (w_rd),
    .b_rd    (b_rd),
    .x_rd    (x_rd)
  );

  llf_seq #(
    .MAX_IN_FEATURES (MAX_IN_FEATURES),
    .IW              (IW),
    .OW              (OW),
    .NIW             (NIW),
    .NOW             (NOW),
    .WAW             (WAW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .n_in        (n_in),
    .n_out       (n_out),
    .bias_en     (bias_enable),
    .token_count (token_count),
    .adv         (adv),
    .busy        (busy),
    .idle        (idle),
    .issue       (issue),
    .x_raddr     (x_raddr),
    .w_raddr     (w_raddr),
    .b_raddr     (b_raddr),
    .last_tok    (last_tok)
  );

  // one multiply and one accumulate per cycle unless the output stalls, results straight to rsp
  llf_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .w_rd     (w_rd),
    .b_rd     (b_rd),
    .x_rd     (x_rd),
    .last_tok (last_tok),
    .adv      (adv),
    .busy     (busy),
    .rsp      (rsp)
  );

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for linear_layer_forward, fully connected layer forward pass
// needs llf_pkg, llf_in_if, llf_out_if and the block with llf_store, llf_mac and llf_seq
`timescale 1ns / 100ps

module tb;
  import llf_pkg::*;

  localparam int MAX_IN      = 64;
  localparam int MAX_OUT     = 64;
  localparam int ITEM_TARGET = 330;     // useful input items to aim for
  localparam int SETTLE      = 16;      // quiet cycles after the last result
  localparam int HOLD_LEN    = 400;     // long receiver hold-off, in cycles
  localparam int CYCLE_LIMIT = 6000000;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  ch;
    logic [5:0]  pos;
    logic [15:0] val;
  } layer_item_t;

  typedef struct {
    logic [47:0] value;
    logic [5:0]  ch;
    logic        last_ch;
    logic        last_tok;
  } dot_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  llf_in_if  req_if ();
  llf_out_if rsp_if ();

  linear_layer_forward DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // layer model: stores, row, token position and register copies
  // ---------------------------------------------------------------------
  logic signed [15:0] model_w [MAX_OUT][MAX_IN];
  logic signed [15:0] model_b [MAX_OUT];
  logic signed [15:0] model_row [MAX_IN];
  int model_tok_pos;
  int cfg_in_feat, cfg_out_feat, cfg_bias_en, cfg_tokens;

  // generator bookkeeping: which store entries hold a written value
  bit w_set [MAX_OUT][MAX_IN];
  bit b_set [MAX_OUT];
  bit r_set [MAX_IN];

  layer_item_t pending_items[$];
  dot_result_t expected_dots[$];
  layer_item_t offered;
  dot_result_t want;

  int pushed_items, useful_items, accepted_items, checked_dots;
  int errors, cfg_writes, phases, cycles;
  int tx_idle_pct, rx_idle_pct;
  logic hold_arm, hold_done;
  int hold_left;

  task automatic report(string what);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int clamp_feat(int raw, int maxv);
    if (raw < 1) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic int n_in_now();
    return clamp_feat(cfg_in_feat, MAX_IN);
  endfunction

  function automatic int n_out_now();
    return clamp_feat(cfg_out_feat, MAX_OUT);
  endfunction

  // applies one accepted item to the layer model and queues the sums it causes
  task automatic layer_predict(layer_item_t it);
    int n_in, n_out, tokens;
    bit last_tok;
    longint acc;
    dot_result_t r;
    case (it.cmd)
      CMD_WEIGHT: model_w[it.ch][it.pos] = it.val;
      CMD_BIAS:   model_b[it.ch] = it.val;
      CMD_ACT: begin
        n_in = n_in_now();
        if (it.pos < n_in) begin
          model_row[it.pos] = it.val;
          // the last feature of the row closes the token
          if (it.pos == n_in - 1) begin
            n_out = n_out_now();
            tokens = (cfg_tokens == 0) ? 1 : cfg_tokens;
            last_tok = (model_tok_pos + 1 >= tokens);
            model_tok_pos = last_tok ? 0 : model_tok_pos + 1;
            for (int o = 0; o < n_out; o++) begin
              acc = cfg_bias_en ? longint'(model_b[o]) * 4096 : 64'sd0;
              for (int i = 0; i < n_in; i++)
                acc += longint'(model_row[i]) * longint'(model_w[o][i]);
              r.value    = acc[47:0];
              r.ch       = 6'(o);
              r.last_ch  = (o == n_out - 1);
              r.last_tok = last_tok;
              expected_dots.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sums still expected", cycles,
               expected_dots.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // driver: offers queued items, predicts each one at its handshake
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid    <= 1'b0;
      req_if.command  <= '0;
      req_if.channel  <= '0;
      req_if.position <= '0;
      req_if.value    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accepted_items++;
        layer_predict(offered);
      end
      // a new item may go out once the current one is taken or none is held
      if (!req_if.valid || req_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = pending_items.pop_front();
          req_if.valid    <= 1'b1;
          req_if.command  <= offered.cmd;
          req_if.channel  <= offered.ch;
          req_if.position <= offered.pos;
          req_if.value    <= offered.val;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side, armed once by the sequence
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks every accepted sum against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
        if (expected_dots.size() == 0) begin
          report($sformatf("sum for channel %0d with nothing expected", rsp_if.out_channel));
        end else begin
          want = expected_dots.pop_front();
          checked_dots++;
          if (rsp_if.out_value !== want.value)
            report($sformatf("channel %0d value %h, wanted %h", want.ch,
                             rsp_if.out_value, want.value));
          if (rsp_if.out_channel !== want.ch)
            report($sformatf("out_channel %0d, wanted %0d", rsp_if.out_channel, want.ch));
          if (rsp_if.last_channel !== want.last_ch)
            report($sformatf("channel %0d last_channel %b, wanted %b", want.ch,
                             rsp_if.last_channel, want.last_ch));
          if (rsp_if.last_token !== want.last_tok)
            report($sformatf("channel %0d last_token %b, wanted %b", want.ch,
                             rsp_if.last_token, want.last_tok));
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  // register write on the plain config port; the block is idle here, so the
  // model copy can follow at once
  task automatic write_cfg(reg_idx_t idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_IN_FEATURES:  cfg_in_feat  = data[6:0];
      REG_OUT_FEATURES: cfg_out_feat = data[6:0];
      REG_BIAS_ENABLE:  cfg_bias_en  = data[0];
      REG_TOKEN_COUNT:  cfg_tokens   = data;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // queues one item and notes which entries it leaves written
  task automatic push_item(logic [1:0] cmd, logic [5:0] ch, logic [5:0] pos,
                           logic [15:0] val);
    layer_item_t it;
    it.cmd = cmd;
    it.ch  = ch;
    it.pos = pos;
    it.val = val;
    pending_items.push_back(it);
    pushed_items++;
    case (cmd)
      CMD_WEIGHT: begin
        w_set[ch][pos] = 1'b1;
        useful_items++;
      end
      CMD_BIAS: begin
        b_set[ch] = 1'b1;
        useful_items++;
      end
      CMD_ACT: begin
        if (pos < n_in_now()) begin
          r_set[pos] = 1'b1;
          useful_items++;
        end
      end
      default: ;
    endcase
  endtask

  // items that are ignored, activations past the row end, or weight and bias loads to random entries
  task automatic add_noise();
    int n_in;
    n_in = n_in_now();
    case ($urandom_range(3))
      0: push_item(CMD_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
      1: begin
        if (n_in < MAX_IN)
          push_item(CMD_ACT, 6'($urandom), 6'($urandom_range(MAX_IN - 1, n_in)),
                    rand_value());
        else
          push_item(CMD_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
      end
      2: push_item(CMD_WEIGHT, 6'($urandom), 6'($urandom), rand_value());
      default: push_item(CMD_BIAS, 6'($urandom), 6'($urandom), rand_value());
    endcase
  endtask

  // every weight and bias the next dot products read gets written first
  task automatic fill_stores();
    int n_in, n_out;
    n_in  = n_in_now();
    n_out = n_out_now();
    for (int o = 0; o < n_out; o++)
      for (int i = 0; i < n_in; i++)
        if (!w_set[o][i]) push_item(CMD_WEIGHT, 6'(o), 6'(i), rand_value());
    for (int o = 0; o < n_out; o++)
      if (!b_set[o]) push_item(CMD_BIAS, 6'(o), 6'($urandom), rand_value());
    // a few overwrites of weights in use
    repeat ($urandom_range(3))
      push_item(CMD_WEIGHT, 6'($urandom_range(n_out - 1)), 6'($urandom_range(n_in - 1)),
                rand_value());
  endtask

  // one token row in shuffled order; features already held may be skipped,
  // and when close is set the closing feature goes last so that it fires the dot products
  task automatic send_row(bit close);
    int n_in, j, tmp;
    int order[$];
    n_in = n_in_now();
    for (int k = 0; k < n_in - 1; k++)
      if (!r_set[k] || $urandom_range(3) != 0) order.push_back(k);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      if ($urandom_range(5) == 0) add_noise();
      push_item(CMD_ACT, 6'($urandom), 6'(order[k]), rand_value());
    end
    if (close) push_item(CMD_ACT, 6'($urandom), 6'(n_in - 1), rand_value());
  endtask

  // waits until every item is in and every sum is out, then lets the
  // pipeline tail settle
  task automatic wait_idle();
    while (accepted_items != pushed_items || expected_dots.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases++;
  endtask

  // receiver idle-heavy first, sender idle-heavy next, then full speed
  task automatic set_idle_mode();
    if (useful_items < 140) begin
      tx_idle_pct = 8;
      rx_idle_pct = 77;
    end else if (useful_items < 280) begin
      tx_idle_pct = 77;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    int p, raw_in, raw_out, rows;
    cfg_we    = 1'b0;
    cfg_index = REG_IN_FEATURES;
    cfg_data  = '0;
    hold_arm  = 1'b0;
    rst       = 1'b1;
    // register defaults after reset
    cfg_in_feat   = 64;
    cfg_out_feat  = 64;
    cfg_bias_en   = 1;
    cfg_tokens    = 1;
    model_tok_pos = 0;
    set_idle_mode();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: a 2x2 layer with full-scale values, batches of two tokens
    write_cfg(REG_IN_FEATURES, 16'd2);
    write_cfg(REG_OUT_FEATURES, 16'd2);
    write_cfg(REG_BIAS_ENABLE, 16'd1);
    write_cfg(REG_TOKEN_COUNT, 16'd2);
    push_item(CMD_WEIGHT, 6'd0, 6'd0, 16'h7fff);
    push_item(CMD_WEIGHT, 6'd0, 6'd1, 16'h8000);
    push_item(CMD_WEIGHT, 6'd1, 6'd0, 16'h8000);
    push_item(CMD_WEIGHT, 6'd1, 6'd1, 16'h7fff);
    push_item(CMD_BIAS, 6'd0, 6'd0, 16'h7fff);
    push_item(CMD_BIAS, 6'd1, 6'd63, 16'h8000);
    // unused command and a feature past the row end, both dropped
    push_item(CMD_UNUSED, 6'd63, 6'd63, 16'hffff);
    push_item(CMD_ACT, 6'd0, 6'd63, 16'h7fff);
    // most negative inputs against full-scale weights
    push_item(CMD_ACT, 6'd0, 6'd0, 16'h8000);
    push_item(CMD_ACT, 6'd0, 6'd1, 16'h8000);
    // second token reuses the held first feature and ends the batch
    push_item(CMD_ACT, 6'd63, 6'd1, 16'h7fff);
    // loads to the top channel and position, outside the layer in use
    push_item(CMD_WEIGHT, 6'd63, 6'd63, 16'h1234);
    push_item(CMD_BIAS, 6'd63, 6'd0, 16'hedcb);
    push_item(CMD_ACT, 6'd0, 6'd0, 16'h7fff);
    push_item(CMD_ACT, 6'd0, 6'd1, 16'h7fff);
    wait_idle();

    // a zero token count behaves as one: every token ends a batch
    write_cfg(REG_TOKEN_COUNT, 16'd0);
    push_item(CMD_ACT, 6'd0, 6'd1, 16'h0001);
    push_item(CMD_ACT, 6'd0, 6'd1, 16'hfffe);
    wait_idle();
    // three tokens into a batch of five, then the count drops below the
    // position reached, so the next token is marked last
    write_cfg(REG_TOKEN_COUNT, 16'd5);
    repeat (3) push_item(CMD_ACT, 6'd0, 6'd1, rand_value());
    wait_idle();
    write_cfg(REG_TOKEN_COUNT, 16'd2);
    push_item(CMD_ACT, 6'd0, 6'd1, rand_value());
    // leave a half-filled row behind for the next size change
    push_item(CMD_ACT, 6'd0, 6'd0, rand_value());
    wait_idle();

    // random phases: new sizes and flags, then token rows
    p = 0;
    while (p < 6 || useful_items < ITEM_TARGET) begin
      set_idle_mode();
      case (p)
        2: begin
          // widest row into a single channel, at times with an over-range count
          raw_in  = $urandom_range(1) ? 64 : 100;
          raw_out = 1;
        end
        3: begin
          // one feature fanned out to every channel
          raw_in  = 0;
          raw_out = $urandom_range(1) ? 64 : 127;
        end
        default: begin
          raw_in  = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
          raw_out = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
        end
      endcase
      write_cfg(REG_IN_FEATURES, 16'(raw_in));
      write_cfg(REG_OUT_FEATURES, 16'(raw_out));
      if (p == 4) write_cfg(REG_BIAS_ENABLE, 16'd0);
      else if ($urandom_range(1)) write_cfg(REG_BIAS_ENABLE, 16'($urandom_range(1)));
      if (p == 5) write_cfg(REG_TOKEN_COUNT, 16'hffff);
      else if ($urandom_range(1)) write_cfg(REG_TOKEN_COUNT, 16'($urandom_range(4)));

      fill_stores();
      rows = (p == 2) ? 1 : (p == 3) ? 3 : $urandom_range(4, 1);
      // hold the result side off while the fan-out rows pile up; the loads
      // go in first so that the hold lands on the rows themselves
      if (p == 3) begin
        while (accepted_items != pushed_items) @(posedge clk);
        @(posedge clk);
        hold_arm <= 1'b1;
      end
      repeat (rows) send_row(1'b1);
      if ($urandom_range(1)) send_row(1'b0);
      wait_idle();
      p++;
    end

    if (expected_dots.size() != 0)
      report($sformatf("%0d sums never arrived", expected_dots.size()));
    $display("covered %0d input items (%0d of them dropped by design), %0d sums checked",
             accepted_items, pushed_items - useful_items, checked_dots);
    $display("over %0d phases and %0d register writes", phases, cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/llf_pkg.sv
rtl/core/llf_in_if.sv
rtl/core/llf_out_if.sv
rtl/core/llf_store.sv
rtl/core/llf_mac.sv
rtl/core/llf_seq.sv
rtl/core/linear_layer_forward.sv
tb/tb.sv
